// File: hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and the CRC-16/MODBUS byte step for the serial
// frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned MaxFrameBytes  = 256;
  localparam int unsigned FrameOverhead  = 5;
  localparam int unsigned HeaderBytes    = 3;
  localparam int unsigned CfgIdxW        = 1;
  localparam int unsigned CfgDataW       = 16;
  localparam int unsigned CntW           = 9;

  localparam logic [7:0]  MaxLength      = 8'(MaxFrameBytes - FrameOverhead);
  localparam logic [7:0]  BroadcastAddr  = 8'hFF;
  localparam logic [15:0] CrcInit        = 16'hFFFF;
  localparam logic [15:0] CrcPoly        = 16'hA001;
  localparam logic [15:0] IdleMax        = 16'hFFFF;
  localparam logic [7:0]  LocalAddrReset = 8'h00;
  localparam logic [15:0] IdleLimitReset = 16'd10;

  localparam logic ModeByte = 1'b0;
  localparam logic ModeTick = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgLocalAddress = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgIdleLimit    = CfgIdxW'(1);

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_GOOD     = 3'd1,
    ST_CRC_ERR  = 3'd2,
    ST_DROP_END = 3'd3,
    ST_TIMEOUT  = 3'd4,
    ST_HDR_REJ  = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0]  local_address;
    logic [15:0] idle_limit;
  } cfg_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic [7:0] byte_index;
    logic       frame_end;
    status_e    status;
  } res_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/sfr_if.sv
// ----------------------------------------------------------------------------
// sfr_if
// Valid/ready channels of the serial frame receiver: input items, results
// and configuration writes.
// ----------------------------------------------------------------------------
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, mode, data_byte, input ready);
  modport sink   (input valid, mode, data_byte, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] out_byte;
  logic [7:0] byte_index;
  logic       frame_end;
  logic [2:0] status;

  modport source (output valid, byte_valid, out_byte, byte_index, frame_end, status,
                  input ready);
  modport sink   (input valid, byte_valid, out_byte, byte_index, frame_end, status,
                  output ready);
endinterface

interface sfr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sfr_pkg::CfgIdxW-1:0]  index;
  logic [sfr_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/sfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// sfr_cfg_regs
// Configuration registers: local address and idle limit.
// ----------------------------------------------------------------------------
module sfr_cfg_regs import sfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfr_cfg_if.sink    cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgLocalAddress: cfg_d.local_address = cfg_i.data[7:0];
        CfgIdleLimit:    cfg_d.idle_limit    = cfg_i.data;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_address <= LocalAddrReset;
      cfg_q.idle_limit    <= IdleLimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/sfr_frame_engine.sv
// ----------------------------------------------------------------------------
// sfr_frame_engine
// Frame state and the per-item step: header check, CRC update, end of frame
// and idle timeout.
// ----------------------------------------------------------------------------
module sfr_frame_engine import sfr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     crc_q, crc_d;
  logic            drop_q, drop_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      dest_q, dest_d;
  logic [15:0]     idle_q, idle_d;

  logic [CntW-1:0] cnt_nxt;
  logic [15:0]     idle_inc;
  logic [15:0]     crc_nxt;
  logic            hdr_rej;
  logic            drop_eff;
  logic            at_end;
  res_t            res;

  always_comb begin
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    drop_d   = drop_q;
    len_d    = len_q;
    dest_d   = dest_q;
    idle_d   = idle_q;
    res      = '{byte_valid: 1'b0, out_byte: 8'h00, byte_index: 8'h00,
                 frame_end: 1'b0, status: ST_NONE};
    idle_inc = (idle_q != IdleMax) ? idle_q + 16'd1 : idle_q;
    cnt_nxt  = cnt_q + CntW'(1);
    if (cnt_q == CntW'(1)) begin
      dest_d = item_i.data_byte;
    end
    if (cnt_q == CntW'(2)) begin
      len_d = item_i.data_byte;
    end
    hdr_rej  = (cnt_nxt == CntW'(HeaderBytes)) &&
               ((len_d > MaxLength) ||
                ((dest_d != BroadcastAddr) && (dest_d != cfg_i.local_address)));
    drop_eff = drop_q | hdr_rej;
    crc_nxt  = drop_eff ? crc_q : crc16_byte(crc_q, item_i.data_byte);
    at_end   = (cnt_nxt >= CntW'(HeaderBytes)) &&
               (cnt_nxt == ({1'b0, len_d} + CntW'(FrameOverhead)));

    if (item_i.mode == ModeTick) begin
      dest_d = dest_q;
      len_d  = len_q;
      idle_d = idle_inc;
      if ((cnt_q != '0) && (idle_inc > cfg_i.idle_limit)) begin
        cnt_d         = '0;
        crc_d         = CrcInit;
        drop_d        = 1'b0;
        res.frame_end = 1'b1;
        res.status    = ST_TIMEOUT;
      end
    end else begin
      idle_d = '0;
      cnt_d  = cnt_nxt;
      crc_d  = crc_nxt;
      drop_d = drop_eff;
      if (hdr_rej) begin
        res.status = ST_HDR_REJ;
      end
      if (!drop_eff) begin
        res.byte_valid = 1'b1;
        res.out_byte   = item_i.data_byte;
        res.byte_index = cnt_q[7:0];
      end
      if (at_end) begin
        res.frame_end = 1'b1;
        if (drop_eff) begin
          res.status = ST_DROP_END;
        end else begin
          res.status = (crc_nxt == 16'h0000) ? ST_GOOD : ST_CRC_ERR;
        end
        cnt_d  = '0;
        crc_d  = CrcInit;
        drop_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      crc_q  <= CrcInit;
      drop_q <= 1'b0;
      len_q  <= '0;
      dest_q <= '0;
      idle_q <= '0;
    end else if (step_i) begin
      cnt_q  <= cnt_d;
      crc_q  <= crc_d;
      drop_q <= drop_d;
      len_q  <= len_d;
      dest_q <= dest_d;
      idle_q <= idle_d;
    end
  end

  assign res_o = res;

`ifndef NO_ASSERTIONS
  a_idle_frame_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> ((crc_q == CrcInit) && !drop_q))
    else $error("frame state not clear with zero byte count");

  a_drop_after_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> (cnt_q >= CntW'(HeaderBytes)))
    else $error("drop flag set before header complete");

  a_end_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res.frame_end) |=> (cnt_q == '0))
    else $error("byte count not cleared at frame end");

  a_forward_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res.byte_valid) |->
      ((res.status != ST_DROP_END) && (res.status != ST_TIMEOUT) &&
       (res.status != ST_HDR_REJ)))
    else $error("forwarded byte with reject status");
`endif

endmodule

// File: hw/rtl/serial_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_unit
// Serial frame receiver with address/length header check, CRC-16/MODBUS
// verification and idle timeout.
// ----------------------------------------------------------------------------
// Takes one item (a received byte or a time tick) per clock and returns one
// result per item. An accepted item waits in the input register, where the
// frame step (header check, one CRC byte step, end and timeout test) runs
// and loads the result register once that register is free or its result is
// taken; the throughput is one item per cycle as long as results are taken.
// The result register and the input register stall together when the
// result is not taken. Configuration writes are taken at once and must only
// happen while no item is in flight.
// ----------------------------------------------------------------------------
module serial_frame_receiver_unit import sfr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfr_in_if.sink    rx_i,
  sfr_out_if.source res_o,
  sfr_cfg_if.sink   cfg_i
);

  logic  in_valid_q, in_valid_d;
  item_t in_item_q;
  logic  out_valid_q, out_valid_d;
  res_t  out_res_q;
  logic  advance;
  logic  step;
  cfg_t  cfg;
  res_t  res;

  sfr_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  sfr_frame_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign advance    = !out_valid_q || res_o.ready;
  assign step       = in_valid_q && advance;
  assign rx_i.ready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (rx_i.valid && rx_i.ready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_item_q.mode      <= rx_i.mode;
      in_item_q.data_byte <= rx_i.data_byte;
    end
    if (step) begin
      out_res_q <= res;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.byte_valid = out_res_q.byte_valid;
  assign res_o.out_byte   = out_res_q.out_byte;
  assign res_o.byte_index = out_res_q.byte_index;
  assign res_o.frame_end  = out_res_q.frame_end;
  assign res_o.status     = out_res_q.status;

endmodule
